/* rtl/core/lzwvd_pkg.sv */
// shared types and constants for the lzw variable width decoder
package lzwvd_pkg;

    localparam int TableSize   = 4096;
    localparam int AddrW       = 12;
    localparam int CodeW       = 12;
    localparam int NfcW        = 13;
    localparam int BufW        = 19;

    localparam logic [CodeW-1:0] CodeClear = 12'd256;
    localparam logic [CodeW-1:0] CodeEnd   = 12'd257;
    localparam logic [CodeW-1:0] CodeFirst = 12'd258;
    localparam logic [NfcW-1:0]  NfcFirst  = 13'd258;
    localparam logic [NfcW-1:0]  NfcLimit  = 13'd4096;
    localparam logic [3:0]       WidthMin  = 4'd9;

    localparam logic [1:0] ErrNone     = 2'd0;
    localparam logic [1:0] ErrBadCode  = 2'd1;
    localparam logic [1:0] ErrFull     = 2'd2;

    localparam logic KindPush = 1'b0;

    typedef struct packed {
        logic       kind;
        logic [7:0] in_byte;
    } in_word_t;

    typedef struct packed {
        logic       accepted;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       finished;
        logic [1:0] error_code;
    } out_word_t;

    // classified word handed from front to back
    typedef struct packed {
        logic       is_push;
        logic [7:0] byte_val;
    } op_t;

    // early change: width grows as the next free code reaches the boundary
    function automatic logic [3:0] next_width(input logic [NfcW-1:0] nfc,
                                              input logic [3:0] width);
        logic [3:0] w;
        w = width;
        if (nfc == 13'd511)
            w = 4'd10;
        else if (nfc == 13'd1023)
            w = 4'd11;
        else if (nfc == 13'd2047)
            w = 4'd12;
        return w;
    endfunction

endpackage

/* rtl/core/lzwvd_front.sv */
// input queue: takes words and classifies them as push or pull
module lzwvd_front
    import lzwvd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_word_t item,
    output logic     op_valid,
    output op_t      op,
    input  logic     op_take
);

    op_t        q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr;
    op_t        cls;

    assign full     = (count_reg == 2'd2);
    assign op_valid = (count_reg != 2'd0);
    assign op       = q_reg[rd_ptr_reg];
    assign do_wr    = push && !full;

    always_comb
    begin
        cls.is_push  = (item.kind == KindPush);
        cls.byte_val = item.in_byte;
        wr_ptr_next  = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next  = op_take ? ~rd_ptr_reg : rd_ptr_reg;
        count_next   = count_reg + {1'b0, do_wr} - {1'b0, op_take};
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            q_reg[wr_ptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/lzwvd_back.sv */
// code unpacking, string table, unwind stack and result queue
module lzwvd_back
    import lzwvd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_valid,
    input  op_t       op,
    output logic      op_take,
    output logic      empty,
    input  logic      pop,
    output out_word_t result
);

    typedef enum logic [1:0] {ST_IDLE, ST_POP, ST_UNW, ST_LAST} state_t;

    // memories
    logic [CodeW-1:0] prefix_mem [TableSize];
    logic [7:0]       suffix_mem [TableSize];
    logic [7:0]       stack_mem  [TableSize];
    logic [CodeW-1:0] pre_q;
    logic [7:0]       suf_q;
    logic [7:0]       stk_q;

    logic             tbl_we;
    logic [AddrW-1:0] tbl_wa;
    logic [CodeW-1:0] tbl_wpre;
    logic [7:0]       tbl_wsuf;
    logic [AddrW-1:0] tbl_ra;
    logic             stk_we;
    logic [AddrW-1:0] stk_wa;
    logic [7:0]       stk_wd;
    logic [AddrW-1:0] stk_ra;

    // decoder state
    state_t           state_reg, state_next;
    logic [BufW-1:0]  buf_reg, buf_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [3:0]       width_reg, width_next;
    logic [NfcW-1:0]  nfc_reg, nfc_next;
    logic [CodeW-1:0] prev_reg, prev_next;
    logic             prev_ok_reg, prev_ok_next;
    logic [7:0]       fop_reg, fop_next;
    logic [NfcW-1:0]  depth_reg, depth_next;
    logic             ended_reg, ended_next;
    logic [1:0]       err_reg, err_next;
    logic [CodeW-1:0] code_reg, code_next;
    logic             add_reg, add_next;
    logic [7:0]       last_reg, last_next;

    // result queue
    out_word_t        oq_reg [2];
    logic             oq_wp_reg, oq_rp_reg;
    logic [1:0]       oq_cnt_reg;
    logic             oq_wr;
    out_word_t        res;
    logic             do_pop;

    // unpacker
    logic [BufW-1:0]  buf_cat;
    logic [4:0]       cnt_sum;
    logic [4:0]       sh;
    logic             has_code;
    logic [CodeW-1:0] code;
    logic [BufW-1:0]  code_mask;

    assign empty  = (oq_cnt_reg == 2'd0);
    assign result = oq_reg[oq_rp_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        buf_cat   = {buf_reg[BufW-9:0], op.byte_val};
        cnt_sum   = cnt_reg + 5'd8;
        has_code  = (cnt_sum >= {1'b0, width_reg});
        sh        = cnt_sum - {1'b0, width_reg};
        code_mask = (19'd1 << width_reg) - 19'd1;
        code      = CodeW'((buf_cat >> sh) & code_mask);
    end

    always_comb
    begin
        state_next   = state_reg;
        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        width_next   = width_reg;
        nfc_next     = nfc_reg;
        prev_next    = prev_reg;
        prev_ok_next = prev_ok_reg;
        fop_next     = fop_reg;
        depth_next   = depth_reg;
        ended_next   = ended_reg;
        err_next     = err_reg;
        code_next    = code_reg;
        add_next     = add_reg;
        last_next    = last_reg;
        tbl_we       = 1'b0;
        tbl_wa       = nfc_reg[AddrW-1:0];
        tbl_wpre     = prev_reg;
        tbl_wsuf     = 8'd0;
        tbl_ra       = pre_q;
        stk_we       = 1'b0;
        stk_wa       = depth_reg[AddrW-1:0];
        stk_wd       = suf_q;
        stk_ra       = AddrW'(depth_reg - 13'd1);
        op_take      = 1'b0;
        oq_wr        = 1'b0;
        res          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (op_valid && oq_cnt_reg != 2'd2)
                begin
                    op_take = 1'b1;
                    if (!op.is_push)
                    begin
                        if (depth_reg != 13'd0)
                        begin
                            depth_next = depth_reg - 13'd1;
                            state_next = ST_POP;
                        end
                        else
                        begin
                            oq_wr        = 1'b1;
                            res.finished = ended_reg;
                            res.error_code = err_reg;
                        end
                    end
                    else if (depth_reg != 13'd0 || ended_reg || err_reg != ErrNone)
                    begin
                        oq_wr          = 1'b1;
                        res.finished   = ended_reg && depth_reg == 13'd0;
                        res.error_code = err_reg;
                    end
                    else
                    begin
                        oq_wr    = 1'b1;
                        buf_next = buf_cat;
                        cnt_next = cnt_sum;
                        if (has_code)
                        begin
                            cnt_next  = sh;
                            buf_next  = buf_cat & ((19'd1 << sh) - 19'd1);
                            code_next = code;
                            if (code == CodeEnd)
                                ended_next = 1'b1;
                            else if (code == CodeClear)
                            begin
                                nfc_next     = NfcFirst;
                                width_next   = WidthMin;
                                prev_ok_next = 1'b0;
                            end
                            else if (!prev_ok_reg && code >= CodeFirst)
                                err_next = ErrBadCode;
                            else if (prev_ok_reg && {1'b0, code} > nfc_reg)
                                err_next = ErrBadCode;
                            else if (prev_ok_reg && nfc_reg >= NfcLimit)
                                err_next = ErrFull;
                            else if (code < CodeClear)
                            begin
                                // literal: single byte string
                                stk_we       = 1'b1;
                                stk_wa       = '0;
                                stk_wd       = code[7:0];
                                depth_next   = 13'd1;
                                if (prev_ok_reg)
                                begin
                                    tbl_we     = 1'b1;
                                    tbl_wsuf   = code[7:0];
                                    nfc_next   = nfc_reg + 13'd1;
                                    width_next = next_width(nfc_reg + 13'd1, width_reg);
                                end
                                prev_next    = code;
                                prev_ok_next = 1'b1;
                                fop_next     = code[7:0];
                            end
                            else if ({1'b0, code} < nfc_reg)
                            begin
                                tbl_ra     = code;
                                add_next   = 1'b1;
                                depth_next = 13'd0;
                                state_next = ST_UNW;
                            end
                            else
                            begin
                                // code equals next free: entry is previous plus its first byte
                                tbl_we     = 1'b1;
                                tbl_wsuf   = fop_reg;
                                nfc_next   = nfc_reg + 13'd1;
                                width_next = next_width(nfc_reg + 13'd1, width_reg);
                                stk_we     = 1'b1;
                                stk_wa     = '0;
                                stk_wd     = fop_reg;
                                depth_next = 13'd1;
                                add_next   = 1'b0;
                                tbl_ra     = prev_reg;
                                last_next  = prev_reg[7:0];
                                state_next = (prev_reg >= CodeFirst) ? ST_UNW : ST_LAST;
                            end
                        end
                        res.accepted   = 1'b1;
                        res.finished   = ended_next && depth_next == 13'd0;
                        res.error_code = err_next;
                    end
                end
            end
            ST_POP:
            begin
                oq_wr          = 1'b1;
                res.data_byte  = stk_q;
                res.data_valid = 1'b1;
                res.finished   = ended_reg && depth_reg == 13'd0;
                res.error_code = err_reg;
                state_next     = ST_IDLE;
            end
            ST_UNW:
            begin
                stk_we     = 1'b1;
                stk_wd     = suf_q;
                depth_next = depth_reg + 13'd1;
                tbl_ra     = pre_q;
                last_next  = pre_q[7:0];
                if (pre_q < CodeFirst)
                    state_next = ST_LAST;
            end
            ST_LAST:
            begin
                stk_we       = 1'b1;
                stk_wd       = last_reg;
                depth_next   = depth_reg + 13'd1;
                fop_next     = last_reg;
                if (add_reg)
                begin
                    tbl_we     = 1'b1;
                    tbl_wsuf   = last_reg;
                    nfc_next   = nfc_reg + 13'd1;
                    width_next = next_width(nfc_reg + 13'd1, width_reg);
                end
                prev_next    = code_reg;
                prev_ok_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            prefix_mem[tbl_wa] <= tbl_wpre;
            suffix_mem[tbl_wa] <= tbl_wsuf;
        end
        pre_q <= prefix_mem[tbl_ra];
        suf_q <= suffix_mem[tbl_ra];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[stk_wa] <= stk_wd;
        stk_q <= stack_mem[stk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (oq_wr)
            oq_reg[oq_wp_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            buf_reg     <= '0;
            cnt_reg     <= '0;
            width_reg   <= WidthMin;
            nfc_reg     <= NfcFirst;
            prev_reg    <= '0;
            prev_ok_reg <= 1'b0;
            fop_reg     <= '0;
            depth_reg   <= '0;
            ended_reg   <= 1'b0;
            err_reg     <= ErrNone;
            code_reg    <= '0;
            add_reg     <= 1'b0;
            last_reg    <= '0;
            oq_wp_reg   <= 1'b0;
            oq_rp_reg   <= 1'b0;
            oq_cnt_reg  <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            buf_reg     <= buf_next;
            cnt_reg     <= cnt_next;
            width_reg   <= width_next;
            nfc_reg     <= nfc_next;
            prev_reg    <= prev_next;
            prev_ok_reg <= prev_ok_next;
            fop_reg     <= fop_next;
            depth_reg   <= depth_next;
            ended_reg   <= ended_next;
            err_reg     <= err_next;
            code_reg    <= code_next;
            add_reg     <= add_next;
            last_reg    <= last_next;
            oq_wp_reg   <= oq_wr ? ~oq_wp_reg : oq_wp_reg;
            oq_rp_reg   <= do_pop ? ~oq_rp_reg : oq_rp_reg;
            oq_cnt_reg  <= oq_cnt_reg + {1'b0, oq_wr} - {1'b0, do_pop};
        end
    end

endmodule

/* rtl/core/lzw_variable_width_decoder.sv */
// top level of the tiff style lzw decoder
// Each word in gives exactly one word out. A pull that returns a byte passes
// through the pop state, which reads the unwind stack, while a pull on an
// empty stack or a push that yields no string or a literal is answered
// from the idle state. A push that completes a code pointing into the table
// walks its prefix chain through the string table at one table read per
// byte, and no further word is started until the string sits on the unwind
// stack. Words queue two deep on both sides, so the input keeps taking words
// while results wait to be popped until both queues fill.
module lzw_variable_width_decoder
    import lzwvd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_word_t  item,
    output logic      empty,
    input  logic      pop,
    output out_word_t result
);

    logic op_valid;
    op_t  op;
    logic op_take;

    lzwvd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .op_valid (op_valid),
        .op       (op),
        .op_take  (op_take)
    );

    lzwvd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op       (op),
        .op_take  (op_take),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule
